// File: hw/rtl/rbr_pkg.sv
// Shared types and constants for the ReLU bound relaxation pipeline.
// No dependencies.
package rbr_pkg;

    localparam int DATA_W  = 32;            // bound / coefficient width
    localparam int INDEX_W = 16;            // neuron index width
    localparam int DIV_W   = DATA_W + 1;    // divisor and remainder width (u + l)

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // Input interval class
    typedef enum logic [1:0] {
        KIND_INACTIVE = 2'd0,   // u <= 0
        KIND_ACTIVE   = 2'd1,   // u > 0, l < 0
        KIND_MIXED    = 2'd2    // u > 0, l >= 0
    } kind_t;

    // Per-item data that rides alongside the divider
    typedef struct packed {
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] l;
        logic signed [DATA_W-1:0] u;
        logic                     last;
        kind_t                    kind;
        logic                     lo_ident;
    } rbr_item_t;

endpackage

// File: hw/rtl/rbr_prep.sv
// Front stage: classifies the interval and sets up the rounded divide.
// Depends on rbr_pkg.
module rbr_prep
    import rbr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  logic [INDEX_W-1:0]       neuron_index,
    input  logic signed [DATA_W-1:0] lower_negated,
    input  logic signed [DATA_W-1:0] upper_bound,
    input  logic                     last_in,
    input  logic                     area_heuristic_on,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output rbr_item_t                dn_item,
    output logic [DIV_W-1:0]         dn_rem,
    output logic [FRAC_BITS:0]       dn_low,
    output logic [DIV_W-1:0]         dn_div
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = DATA_W + FRAC_BITS;   // rounded dividend width

    logic              valid_reg;
    rbr_item_t         item_reg, item_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [QW-1:0]     low_reg, low_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [NW-1:0]     dividend;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        item_next.index = neuron_index;
        item_next.l     = lower_negated;
        item_next.u     = upper_bound;
        item_next.last  = last_in;
        if (upper_bound <= 0)
            item_next.kind = KIND_INACTIVE;
        else if (lower_negated < 0)
            item_next.kind = KIND_ACTIVE;
        else
            item_next.kind = KIND_MIXED;
        item_next.lo_ident = area_heuristic_on && (upper_bound >= lower_negated);

        // u*ONE + floor((u+l)/2); only meaningful for the mixed class
        div_next = {upper_bound[DATA_W-1], upper_bound}
                 + {lower_negated[DATA_W-1], lower_negated};
        dividend = (NW'(upper_bound[DATA_W-2:0]) << FRAC_BITS)
                 + NW'(div_next[DIV_W-1:1]);
        rem_next = DIV_W'(dividend[NW-1:QW]);
        low_next = dividend[QW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= item_next;
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            div_reg  <= div_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;
    assign dn_rem   = rem_reg;
    assign dn_low   = low_reg;
    assign dn_div   = div_reg;

endmodule

// File: hw/rtl/rbr_div_cell.sv
// One restoring-division cell: resolves one quotient bit per item.
// Depends on rbr_pkg.
module rbr_div_cell
    import rbr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  rbr_item_t          up_item,
    input  logic [DIV_W-1:0]   up_rem,
    input  logic [FRAC_BITS:0] up_low,
    input  logic [FRAC_BITS:0] up_q,
    input  logic [DIV_W-1:0]   up_div,
    output logic               dn_valid,
    input  logic               dn_ready,
    output rbr_item_t          dn_item,
    output logic [DIV_W-1:0]   dn_rem,
    output logic [FRAC_BITS:0] dn_low,
    output logic [FRAC_BITS:0] dn_q,
    output logic [DIV_W-1:0]   dn_div
);

    localparam int QW = FRAC_BITS + 1;

    logic             valid_reg;
    rbr_item_t        item_reg;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    low_reg, low_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             take;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        trial    = {up_rem, up_low[QW-1]};
        diff     = trial - {1'b0, up_div};
        take     = trial >= {1'b0, up_div};
        rem_next = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        low_next = {up_low[QW-2:0], 1'b0};
        q_next   = {up_q[QW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            q_reg    <= q_next;
            div_reg  <= up_div;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;
    assign dn_rem   = rem_reg;
    assign dn_low   = low_reg;
    assign dn_q     = q_reg;
    assign dn_div   = div_reg;

endmodule

// File: hw/rtl/rbr_post.sv
// Back end: intercept multiply, rounding, field select and output register.
// Depends on rbr_pkg.
module rbr_post
    import rbr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  rbr_item_t                up_item,
    input  logic [FRAC_BITS:0]       up_q,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [INDEX_W-1:0]       index_out,
    output logic signed [DATA_W-1:0] out_lower_negated,
    output logic signed [DATA_W-1:0] out_upper,
    output logic signed [DATA_W-1:0] low_coeff_inf,
    output logic signed [DATA_W-1:0] low_coeff_sup,
    output logic signed [DATA_W-1:0] up_coeff_inf,
    output logic signed [DATA_W-1:0] up_coeff_sup,
    output logic signed [DATA_W-1:0] up_const_inf,
    output logic signed [DATA_W-1:0] up_const_sup,
    output logic                     last_out
);

    localparam int QW = FRAC_BITS + 1;
    localparam int PW = QW + DATA_W;   // product width with headroom for rounding
    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    // Multiply stage
    logic             mul_valid_reg;
    rbr_item_t        mul_item_reg;
    logic [QW-1:0]    mul_s_reg;
    logic [PW-1:0]    prod_reg;
    logic             mul_ready;

    // Output stage
    logic                     out_valid_reg;
    logic                     out_ready;
    logic [INDEX_W-1:0]       index_reg;
    logic signed [DATA_W-1:0] lneg_reg, lneg_next;
    logic signed [DATA_W-1:0] upper_reg, upper_next;
    logic signed [DATA_W-1:0] lo_inf_reg, lo_inf_next;
    logic signed [DATA_W-1:0] lo_sup_reg, lo_sup_next;
    logic signed [DATA_W-1:0] up_inf_reg, up_inf_next;
    logic signed [DATA_W-1:0] up_sup_reg, up_sup_next;
    logic signed [DATA_W-1:0] cst_inf_reg, cst_inf_next;
    logic signed [DATA_W-1:0] cst_sup_reg, cst_sup_next;
    logic                     last_reg;
    logic [PW-1:0]            rounded;
    logic [DATA_W:0]          c_wide;
    logic signed [DATA_W-1:0] c_sat;
    logic signed [DATA_W-1:0] s_ext;

    assign out_ready = !out_valid_reg || !out_stall;
    assign mul_ready = !mul_valid_reg || out_ready;
    assign up_ready  = mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
                mul_valid_reg <= up_valid;
            if (out_ready)
                out_valid_reg <= mul_valid_reg;
        end
    end

    // s * l; l is non-negative whenever the product is used
    always_ff @(posedge clk)
    begin
        if (up_valid && mul_ready)
        begin
            mul_item_reg <= up_item;
            mul_s_reg    <= up_q;
            prod_reg     <= PW'(up_q) * PW'(up_item.l[DATA_W-2:0]);
        end
    end

    always_comb
    begin
        rounded = prod_reg + (PW'(1) << (FRAC_BITS - 1));
        c_wide  = (DATA_W + 1)'(rounded >> FRAC_BITS);
        c_sat   = (c_wide[DATA_W:DATA_W-1] != 2'b00) ? SAT_MAX : c_wide[DATA_W-1:0];
        s_ext   = DATA_W'(mul_s_reg);

        lneg_next  = (mul_item_reg.l < 0) ? mul_item_reg.l : '0;
        upper_next = (mul_item_reg.u > 0) ? mul_item_reg.u : '0;

        lo_inf_next  = '0;
        lo_sup_next  = '0;
        up_inf_next  = '0;
        up_sup_next  = '0;
        cst_inf_next = '0;
        cst_sup_next = '0;
        case (mul_item_reg.kind)
            KIND_ACTIVE:
            begin
                lo_inf_next = -ONE;
                lo_sup_next = ONE;
                up_inf_next = -ONE;
                up_sup_next = ONE;
            end
            KIND_MIXED:
            begin
                if (mul_item_reg.lo_ident)
                begin
                    lo_inf_next = -ONE;
                    lo_sup_next = ONE;
                end
                up_inf_next  = -s_ext;
                up_sup_next  = s_ext;
                cst_inf_next = -c_sat;
                cst_sup_next = c_sat;
            end
            default:
            begin
                // inactive: all zero
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid_reg && out_ready)
        begin
            index_reg   <= mul_item_reg.index;
            lneg_reg    <= lneg_next;
            upper_reg   <= upper_next;
            lo_inf_reg  <= lo_inf_next;
            lo_sup_reg  <= lo_sup_next;
            up_inf_reg  <= up_inf_next;
            up_sup_reg  <= up_sup_next;
            cst_inf_reg <= cst_inf_next;
            cst_sup_reg <= cst_sup_next;
            last_reg    <= mul_item_reg.last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign index_out         = index_reg;
    assign out_lower_negated = lneg_reg;
    assign out_upper         = upper_reg;
    assign low_coeff_inf     = lo_inf_reg;
    assign low_coeff_sup     = lo_sup_reg;
    assign up_coeff_inf      = up_inf_reg;
    assign up_coeff_sup      = up_sup_reg;
    assign up_const_inf      = cst_inf_reg;
    assign up_const_sup      = cst_sup_reg;
    assign last_out          = last_reg;

endmodule

// File: hw/rtl/relu_bound_relaxation.sv
// ReLU bound relaxation. An item passes from input accept to result valid through
// one setup stage, FRAC_BITS + 1 divider cells, one multiply stage and one output register.
// One item per cycle while out_stall is low; each divider cell resolves one quotient bit.
// Reset (rst_n, async low): all stage valids cleared, area_heuristic_on set to 1.
// Depends on rbr_pkg, rbr_prep, rbr_div_cell, rbr_post.
module relu_bound_relaxation
    import rbr_pkg::*;
#(
    parameter int FRAC_BITS = 16    // fraction bits of the fixed-point format, 8..30
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     cfg_write,
    input  logic                     cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [INDEX_W-1:0]       neuron_index,
    input  logic signed [DATA_W-1:0] lower_negated,
    input  logic signed [DATA_W-1:0] upper_bound,
    input  logic                     last_in,
    // output channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [INDEX_W-1:0]       index_out,
    output logic signed [DATA_W-1:0] out_lower_negated,
    output logic signed [DATA_W-1:0] out_upper,
    output logic signed [DATA_W-1:0] low_coeff_inf,
    output logic signed [DATA_W-1:0] low_coeff_sup,
    output logic signed [DATA_W-1:0] up_coeff_inf,
    output logic signed [DATA_W-1:0] up_coeff_sup,
    output logic signed [DATA_W-1:0] up_const_inf,
    output logic signed [DATA_W-1:0] up_const_sup,
    output logic                     last_out
);

    // Quotient s = round(u * ONE / (u + l)) is at most ONE, so it needs
    // FRAC_BITS + 1 bits and as many divider cells.
    localparam int QW     = FRAC_BITS + 1;
    localparam int NCELLS = QW;

    logic area_heuristic_on_reg;

    // Stage taps: index 0 is the setup stage output, index k the output of cell k-1
    logic             stg_valid [0:NCELLS];
    logic             stg_ready [0:NCELLS];
    rbr_item_t        stg_item  [0:NCELLS];
    logic [DIV_W-1:0] stg_rem   [0:NCELLS];
    logic [QW-1:0]    stg_low   [0:NCELLS];
    logic [QW-1:0]    stg_q     [0:NCELLS];
    logic [DIV_W-1:0] stg_div   [0:NCELLS];
    logic             in_ready;

    // Configuration register; user must write it only while pipeline empty; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            area_heuristic_on_reg <= 1'b1;
        else if (cfg_write)
            area_heuristic_on_reg <= cfg_data;
    end

    assign in_stall = !in_ready;

    // Setup: interval class, divisor u + l and rounded dividend u*ONE + (u+l)/2
    rbr_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk               (clk),
        .rst_n             (rst_n),
        .up_valid          (in_valid),
        .up_ready          (in_ready),
        .neuron_index      (neuron_index),
        .lower_negated     (lower_negated),
        .upper_bound       (upper_bound),
        .last_in           (last_in),
        .area_heuristic_on (area_heuristic_on_reg),
        .dn_valid          (stg_valid[0]),
        .dn_ready          (stg_ready[0]),
        .dn_item           (stg_item[0]),
        .dn_rem            (stg_rem[0]),
        .dn_low            (stg_low[0]),
        .dn_div            (stg_div[0])
    );

    assign stg_q[0] = '0;

    // Chain of restoring-division cells, MSB of the quotient first.
    // Each stage advances when it is empty or its successor advances, so
    // bubbles collapse while the output is held.
    for (genvar k = 0; k < NCELLS; k++)
    begin : g_cell
        rbr_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[k]),
            .up_ready (stg_ready[k]),
            .up_item  (stg_item[k]),
            .up_rem   (stg_rem[k]),
            .up_low   (stg_low[k]),
            .up_q     (stg_q[k]),
            .up_div   (stg_div[k]),
            .dn_valid (stg_valid[k+1]),
            .dn_ready (stg_ready[k+1]),
            .dn_item  (stg_item[k+1]),
            .dn_rem   (stg_rem[k+1]),
            .dn_low   (stg_low[k+1]),
            .dn_q     (stg_q[k+1]),
            .dn_div   (stg_div[k+1])
        );
    end

    // Intercept c = round(s * l / ONE), field selection, output register.
    // Remainder, leftover dividend bits and divisor are dropped after the last cell.
    rbr_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .clk               (clk),
        .rst_n             (rst_n),
        .up_valid          (stg_valid[NCELLS]),
        .up_ready          (stg_ready[NCELLS]),
        .up_item           (stg_item[NCELLS]),
        .up_q              (stg_q[NCELLS]),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .index_out         (index_out),
        .out_lower_negated (out_lower_negated),
        .out_upper         (out_upper),
        .low_coeff_inf     (low_coeff_inf),
        .low_coeff_sup     (low_coeff_sup),
        .up_coeff_inf      (up_coeff_inf),
        .up_coeff_sup      (up_coeff_sup),
        .up_const_inf      (up_const_inf),
        .up_const_sup      (up_const_sup),
        .last_out          (last_out)
    );

endmodule

// File: hw/rtl/rbr_checker.sv
// Port-level checks for relu_bound_relaxation, attached with a bind.
// Depends on rbr_pkg and relu_bound_relaxation.
module rbr_checker
    import rbr_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [DATA_W-1:0] out_lower_negated,
    input logic signed [DATA_W-1:0] out_upper,
    input logic signed [DATA_W-1:0] low_coeff_inf,
    input logic signed [DATA_W-1:0] low_coeff_sup,
    input logic signed [DATA_W-1:0] up_coeff_inf,
    input logic signed [DATA_W-1:0] up_coeff_sup,
    input logic signed [DATA_W-1:0] up_const_inf,
    input logic signed [DATA_W-1:0] up_const_sup
);

    // A held result stays valid, with its upper slope and upper bound stable
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(up_coeff_sup) && $stable(out_upper))
        else $error("result changed while stalled");

    // ReLU output interval never crosses zero
    a_relu_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_lower_negated <= 0 && out_upper >= 0)
        else $error("ReLU interval out of range");

    // Negated infimum mirrors supremum for every relaxation term
    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> up_coeff_inf == -up_coeff_sup && up_const_inf == -up_const_sup
                      && low_coeff_inf == -low_coeff_sup)
        else $error("inf/sup mismatch");

    // Inactive neuron gives a zero upper relaxation and a zero lower slope
    a_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_upper == 0 |-> up_coeff_sup == 0 && up_const_sup == 0
                                        && low_coeff_sup == 0)
        else $error("nonzero relaxation for inactive neuron");

    // Upper slope and intercept (sup side) are never negative
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> up_coeff_sup >= 0 && up_const_sup >= 0)
        else $error("negative upper relaxation");

endmodule

bind relu_bound_relaxation rbr_checker u_rbr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_lower_negated (out_lower_negated),
    .out_upper         (out_upper),
    .low_coeff_inf     (low_coeff_inf),
    .low_coeff_sup     (low_coeff_sup),
    .up_coeff_inf      (up_coeff_inf),
    .up_coeff_sup      (up_coeff_sup),
    .up_const_inf      (up_const_inf),
    .up_const_sup      (up_const_sup)
);
